/* rtl/core/object_to_ego_frame_matcher_top_defines.svh */
// Assertion macros shared by the object-to-ego-frame matcher RTL.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef OBJECT_TO_EGO_FRAME_MATCHER_TOP_DEFINES_SVH
`define OBJECT_TO_EGO_FRAME_MATCHER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define OTEM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define OTEM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/otem_pkg.sv */
// Shared types and constants for the object-to-ego-frame matcher.
// No dependencies; imported by every module of the block.
package otem_pkg;

  // field widths
  localparam int POS_W      = 40;              // absolute positions
  localparam int DIFF_W     = POS_W + 1;       // exact position offset
  localparam int ROT_W      = 16;              // Q2.14 rotation terms
  localparam int PROD_W     = DIFF_W + ROT_W;  // one rotation product
  localparam int SUM_W      = PROD_W + 1;      // sum of two products
  localparam int FRAC_W     = 14;              // fraction bits of Q2.14
  localparam int SHR_W      = SUM_W - FRAC_W;  // rounded, before saturation
  localparam int REL_W      = 32;              // ego-frame coordinates
  localparam int ERR_W      = REL_W + 1;       // target minus position
  localparam int NEAR_W     = 21;              // magnitude bound for the square
  localparam int SQ_W       = 2 * NEAR_W;      // one square
  localparam int DIST_W     = SQ_W + 1;        // sum of squares
  localparam int RAD_W      = 40;              // squared radius
  localparam int VIDX_W     = 8;               // reported vehicle index
  localparam int TIDX_W     = 9;               // reported target index
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 40;

  localparam int MAX_VEH_DEF = 256;
  localparam int Q_DEPTH_DEF = 4;

  localparam logic [SUM_W-1:0]  ROUND_HALF = SUM_W'(1 << (FRAC_W - 1));
  localparam logic [TIDX_W-1:0] MATCH_NONE = '1;

  // reset values of the registers
  localparam logic [ROT_W-1:0] ROT_COS_RST = ROT_W'(16384);
  localparam logic [RAD_W-1:0] RADIUS_RST  = RAD_W'(16384);

  typedef enum logic [1:0] {
    MF_OFF = 2'd0,
    MF_IN  = 2'd1,
    MF_OUT = 2'd2
  } match_flag_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EGO_X        = 4'd0,
    REG_EGO_Y        = 4'd1,
    REG_ROT_COS      = 4'd2,
    REG_ROT_SIN      = 4'd3,
    REG_TARGET_VALID = 4'd4,
    REG_TARGET_X     = 4'd5,
    REG_TARGET_Y     = 4'd6,
    REG_RADIUS       = 4'd7
  } cfg_reg_t;

  // register file contents as seen by the front and back
  typedef struct packed {
    logic signed [POS_W-1:0]  ego_x;
    logic signed [POS_W-1:0]  ego_y;
    logic signed [ROT_W-1:0]  rot_cos;
    logic signed [ROT_W-1:0]  rot_sin;
    logic                     target_valid;
    logic signed [REL_W-1:0]  target_x;
    logic signed [REL_W-1:0]  target_y;
    logic        [RAD_W-1:0]  radius_sq;
  } cfg_t;

  // one queued word: offset from ego plus list bookkeeping
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic        [TIDX_W-1:0] idx;
    logic                     last;
  } item_t;

endpackage

/* rtl/core/otem_front.sv */
// Front end: accepts vehicle words, numbers them within the list, forms ego offsets.
// Depends on otem_pkg; feeds otem_queue.
module otem_front import otem_pkg::*; #(
  parameter int MAX_VEHICLES = MAX_VEH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [POS_W-1:0] in_veh_x,
  input  logic signed [POS_W-1:0] in_veh_y,
  input  logic                    in_last_vehicle,
  input  logic                    q_full,
  input  cfg_t                    cfg,
  output logic                    push,
  output item_t                   item
);

  localparam int CNT_W = $clog2(MAX_VEHICLES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VEHICLES - 1);

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W+TIDX_W-1:0] cnt_ext;

  assign push    = in_valid && !q_full;
  assign cnt_ext = {{TIDX_W{1'b0}}, cnt_r};

  // offset from ego, exact in one extra bit
  always_comb begin
    item.dx   = DIFF_W'(in_veh_x) - DIFF_W'(cfg.ego_x);
    item.dy   = DIFF_W'(in_veh_y) - DIFF_W'(cfg.ego_y);
    item.idx  = cnt_ext[TIDX_W-1:0];
    item.last = in_last_vehicle;
  end

  // list position: restart after the last vehicle, hold at the top
  always_comb begin
    cnt_nxt = cnt_r;
    if (push) begin
      if (in_last_vehicle) begin
        cnt_nxt = '0;
      end else if (cnt_r != CNT_MAX) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/otem_queue.sv */
// Short word queue between front and back; register storage, one read port.
// Depends on otem_pkg for the queued word type.
`include "object_to_ego_frame_matcher_top_defines.svh"

module otem_queue import otem_pkg::*; #(
  parameter int DEPTH = Q_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_item,
  input  logic  pop,
  output item_t rd_item,
  output logic  full,
  output logic  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign rd_item = mem_r[rd_ptr_r];

  // pointer wrap and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  `OTEM_ASSERT_IMP(a_q_no_overflow, push, !full, "queue written while full")
  `OTEM_ASSERT_NXT(a_q_fill_seen, push && !pop, !empty, "queue empty after a lone write")

endmodule

/* rtl/core/otem_back.sv */
// Back end: rotation, rounding and saturation, radius test and match tracking.
// Depends on otem_pkg; drains otem_queue and holds the output register.
`include "object_to_ego_frame_matcher_top_defines.svh"

module otem_back import otem_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     q_empty,
  input  item_t                    q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [REL_W-1:0]  out_rel_x,
  output logic signed [REL_W-1:0]  out_rel_y,
  output logic        [1:0]        out_match_flag,
  output logic        [VIDX_W-1:0] out_vehicle_index,
  output logic signed [TIDX_W-1:0] out_target_index,
  output logic                     out_list_end
);

  typedef struct packed {
    logic [TIDX_W-1:0] idx;
    logic              last;
  } tag_t;

  // narrow the result to 32 bits with clipping
  function automatic logic signed [REL_W-1:0] sat_rel(input logic signed [SHR_W-1:0] v);
    logic [SHR_W-REL_W:0] top;
    top = v[SHR_W-1:REL_W-1];
    if (top == '0 || top == '1) begin
      sat_rel = v[REL_W-1:0];
    end else if (v[SHR_W-1]) begin
      sat_rel = {1'b1, {(REL_W-1){1'b0}}};
    end else begin
      sat_rel = {1'b0, {(REL_W-1){1'b1}}};
    end
  endfunction

  logic adv;

  // stage valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, out_valid_r;

  // stage payloads
  tag_t                     t1_r, t2_r, t3_r, t4_r, t5_r, t6_r;
  logic signed [PROD_W-1:0] p_xc_r, p_ys_r, p_xs_r, p_yc_r;
  logic signed [SUM_W-1:0]  s_x_r, s_y_r;
  logic signed [REL_W-1:0]  rx3_r, ry3_r, rx4_r, ry4_r, rx5_r, ry5_r, rx6_r, ry6_r;
  logic signed [ERR_W-1:0]  ex_r, ey_r;
  logic        [NEAR_W-1:0] ax_r, ay_r;
  logic                     near5_r, near6_r;
  logic        [SQ_W-1:0]   sqx_r, sqy_r;

  // output and list state
  logic signed [REL_W-1:0]  out_rel_x_r, out_rel_y_r;
  match_flag_t              out_flag_r, flag_nxt;
  logic        [VIDX_W-1:0] out_vehicle_index_r;
  logic        [TIDX_W-1:0] out_target_index_r;
  logic                     out_list_end_r;
  logic        [TIDX_W-1:0] match_r, match_nxt, match_new;

  // combinational helpers
  logic signed [SHR_W-1:0] shr_x, shr_y;
  logic        [ERR_W-1:0] abs_x, abs_y;
  logic        [DIST_W-1:0] dist_sq;
  logic                    in_radius;

  // whole pipeline moves unless the output word is held
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  assign shr_x = s_x_r[SUM_W-1:FRAC_W];
  assign shr_y = s_y_r[SUM_W-1:FRAC_W];
  assign abs_x = ex_r[ERR_W-1] ? ERR_W'(-ex_r) : ERR_W'(ex_r);
  assign abs_y = ey_r[ERR_W-1] ? ERR_W'(-ey_r) : ERR_W'(ey_r);
  assign dist_sq   = DIST_W'(sqx_r) + DIST_W'(sqy_r);
  assign in_radius = near6_r && (dist_sq < DIST_W'(cfg.radius_sq));

  // flag and latest match for the word entering the output register
  always_comb begin
    flag_nxt  = MF_OFF;
    match_new = match_r;
    if (cfg.target_valid) begin
      if (in_radius) begin
        flag_nxt  = MF_IN;
        match_new = t6_r.idx;
      end else begin
        flag_nxt = MF_OUT;
      end
    end
    match_nxt = match_r;
    if (adv && v6_r) begin
      match_nxt = t6_r.last ? MATCH_NONE : match_new;
    end
  end

  // control: valids and match index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
      match_r     <= MATCH_NONE;
    end else begin
      if (adv) begin
        v1_r        <= q_pop;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        v4_r        <= v3_r;
        v5_r        <= v4_r;
        v6_r        <= v5_r;
        out_valid_r <= v6_r;
      end
      match_r <= match_nxt;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // multiply by the rotation terms
      p_xc_r <= q_item.dx * cfg.rot_cos;
      p_ys_r <= q_item.dy * cfg.rot_sin;
      p_xs_r <= q_item.dx * cfg.rot_sin;
      p_yc_r <= q_item.dy * cfg.rot_cos;
      t1_r   <= '{idx: q_item.idx, last: q_item.last};
      // combine products, add half for rounding
      s_x_r <= SUM_W'(p_xc_r) - SUM_W'(p_ys_r) + $signed(ROUND_HALF);
      s_y_r <= SUM_W'(p_xs_r) + SUM_W'(p_yc_r) + $signed(ROUND_HALF);
      t2_r  <= t1_r;
      // floor shift and clip
      rx3_r <= sat_rel(shr_x);
      ry3_r <= sat_rel(shr_y);
      t3_r  <= t2_r;
      // error against target
      ex_r  <= ERR_W'(cfg.target_x) - ERR_W'(rx3_r);
      ey_r  <= ERR_W'(cfg.target_y) - ERR_W'(ry3_r);
      rx4_r <= rx3_r;
      ry4_r <= ry3_r;
      t4_r  <= t3_r;
      // magnitudes; far errors can never be inside
      ax_r    <= abs_x[NEAR_W-1:0];
      ay_r    <= abs_y[NEAR_W-1:0];
      near5_r <= (abs_x[ERR_W-1:NEAR_W] == '0) && (abs_y[ERR_W-1:NEAR_W] == '0);
      rx5_r   <= rx4_r;
      ry5_r   <= ry4_r;
      t5_r    <= t4_r;
      // squares
      sqx_r   <= ax_r * ax_r;
      sqy_r   <= ay_r * ay_r;
      near6_r <= near5_r;
      rx6_r   <= rx5_r;
      ry6_r   <= ry5_r;
      t6_r    <= t5_r;
      // output word
      out_rel_x_r         <= rx6_r;
      out_rel_y_r         <= ry6_r;
      out_flag_r          <= flag_nxt;
      out_vehicle_index_r <= t6_r.idx[VIDX_W-1:0];
      out_target_index_r  <= match_new;
      out_list_end_r      <= t6_r.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rel_x         = out_rel_x_r;
  assign out_rel_y         = out_rel_y_r;
  assign out_match_flag    = out_flag_r;
  assign out_vehicle_index = out_vehicle_index_r;
  assign out_target_index  = out_target_index_r;
  assign out_list_end      = out_list_end_r;

  `OTEM_ASSERT_IMP(a_pop_has_word, q_pop, !q_empty, "pop from empty queue")
  `OTEM_ASSERT_IMP(a_hit_index, out_valid_r && out_flag_r == MF_IN, out_target_index_r[VIDX_W-1:0] == out_vehicle_index_r, "hit word does not report its own index")
  `OTEM_ASSERT_IMP(a_list_cleared, out_valid_r && out_list_end_r, match_r == MATCH_NONE, "match index not cleared at list end")

endmodule

/* rtl/core/object_to_ego_frame_matcher_top.sv */
// Path: queue, then product, sum, clip, error, magnitude, square and output registers.
// Throughput: one word per cycle when not held; the four-multiplier rotation pipeline
// sets the pace; while the output is held, a 4-word queue absorbs input until full.
// Back pipeline freezes as a whole while the output word is held.
// Reset (rst_n, synchronous, active low) clears valids, list counter, match index
// and loads register defaults; no storage sweep follows, words accepted at once.
module object_to_ego_frame_matcher_top import otem_pkg::*; #(
  parameter int MAX_VEHICLES = MAX_VEH_DEF,
  parameter int QUEUE_DEPTH  = Q_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // vehicle words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [POS_W-1:0]     in_veh_x,
  input  logic signed [POS_W-1:0]     in_veh_y,
  input  logic                        in_last_vehicle,
  // result words
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [REL_W-1:0]     out_rel_x,
  output logic signed [REL_W-1:0]     out_rel_y,
  output logic        [1:0]           out_match_flag,
  output logic        [VIDX_W-1:0]    out_vehicle_index,
  output logic signed [TIDX_W-1:0]    out_target_index,
  output logic                        out_list_end,
  // register writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  item_t f_item, q_item;
  logic  push, pop, q_full, q_empty;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ego_x        <= '0;
      cfg_r.ego_y        <= '0;
      cfg_r.rot_cos      <= ROT_COS_RST;
      cfg_r.rot_sin      <= '0;
      cfg_r.target_valid <= 1'b0;
      cfg_r.target_x     <= '0;
      cfg_r.target_y     <= '0;
      cfg_r.radius_sq    <= RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_EGO_X:        cfg_r.ego_x        <= cfg_data[POS_W-1:0];
        REG_EGO_Y:        cfg_r.ego_y        <= cfg_data[POS_W-1:0];
        REG_ROT_COS:      cfg_r.rot_cos      <= cfg_data[ROT_W-1:0];
        REG_ROT_SIN:      cfg_r.rot_sin      <= cfg_data[ROT_W-1:0];
        REG_TARGET_VALID: cfg_r.target_valid <= cfg_data[0];
        REG_TARGET_X:     cfg_r.target_x     <= cfg_data[REL_W-1:0];
        REG_TARGET_Y:     cfg_r.target_y     <= cfg_data[REL_W-1:0];
        REG_RADIUS:       cfg_r.radius_sq    <= cfg_data[RAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  otem_front #(.MAX_VEHICLES(MAX_VEHICLES)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_veh_x        (in_veh_x),
    .in_veh_y        (in_veh_y),
    .in_last_vehicle (in_last_vehicle),
    .q_full          (q_full),
    .cfg             (cfg_r),
    .push            (push),
    .item            (f_item)
  );

  otem_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (f_item),
    .pop     (pop),
    .rd_item (q_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  otem_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_item            (q_item),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rel_x         (out_rel_x),
    .out_rel_y         (out_rel_y),
    .out_match_flag    (out_match_flag),
    .out_vehicle_index (out_vehicle_index),
    .out_target_index  (out_target_index),
    .out_list_end      (out_list_end)
  );

endmodule

/* dv/object_to_ego_frame_matcher_top_tb.sv */
// Self-checking bench for object_to_ego_frame_matcher_top: drives vehicle words and
// register writes, predicts each result word and checks it field by field.
// Depends on otem_pkg for widths, the match flag codes and the register indexes.
module object_to_ego_frame_matcher_top_tb;
  import otem_pkg::*;

  localparam int          RESET_CYCLES  = 4;
  localparam int          SETTLE_CYCLES = 10;
  localparam int          DRAIN_CYCLES  = 12;
  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int          RAND_ITEMS    = 650;
  localparam int          LONG_LIST     = 270;  // runs past the index counter hold
  localparam int          REG_COUNT     = 8;
  localparam real         PI            = 3.14159265358979;

  localparam longint POS_MAX  = 64'sd549755813887;
  localparam longint POS_MIN  = -64'sd549755813888;
  localparam longint REL_MAX  = 64'sd2147483647;
  localparam longint REL_MIN  = -64'sd2147483648;
  localparam longint NEAR_LIM = 64'sd2097152;
  localparam longint RAD_MAX  = 64'sd1099511627775;

  typedef enum logic [1:0] {
    W_VEHICLE,
    W_WRITE,
    W_SETTLE
  } word_kind_t;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_LIGHT,
    ST_HEAVY,
    ST_PERIODIC
  } stall_mode_t;

  typedef struct {
    word_kind_t              kind;
    logic signed [POS_W-1:0] veh_x;
    logic signed [POS_W-1:0] veh_y;
    logic                    is_last;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_data;
  } pending_word_t;

  typedef struct {
    logic signed [REL_W-1:0]  rel_x;
    logic signed [REL_W-1:0]  rel_y;
    match_flag_t              flag;
    logic        [VIDX_W-1:0] vidx;
    logic signed [TIDX_W-1:0] tidx;
    logic                     lend;
  } ego_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                        in_valid        = 1'b0;
  logic                        in_stall;
  logic signed [POS_W-1:0]     in_veh_x        = '0;
  logic signed [POS_W-1:0]     in_veh_y        = '0;
  logic                        in_last_vehicle = 1'b0;
  logic                        out_valid;
  logic                        out_stall       = 1'b0;
  logic signed [REL_W-1:0]     out_rel_x;
  logic signed [REL_W-1:0]     out_rel_y;
  logic        [1:0]           out_match_flag;
  logic        [VIDX_W-1:0]    out_vehicle_index;
  logic signed [TIDX_W-1:0]    out_target_index;
  logic                        out_list_end;
  logic                        cfg_valid       = 1'b0;
  logic                        cfg_ready;
  logic        [CFG_IDX_W-1:0] cfg_index       = '0;
  logic        [CFG_DATA_W-1:0] cfg_data       = '0;

  pending_word_t pending_words[$];
  ego_result_t   expected_results[$];
  int            n_errors = 0;

  // register shadows, reset values
  longint cfg_ego_x  = 0;
  longint cfg_ego_y  = 0;
  longint cfg_cos    = 16384;
  longint cfg_sin    = 0;
  bit     cfg_tvalid = 1'b0;
  longint cfg_tgt_x  = 0;
  longint cfg_tgt_y  = 0;
  longint cfg_radius = 16384;

  // list bookkeeping
  int list_count = 0;
  int list_match = -1;

  // sender pacing
  int gap_left   = 0;
  int burst_left = 0;
  int settle_cnt = 0;

  // receiver pacing
  stall_mode_t stall_mode  = ST_NONE;
  int          stall_left  = 0;
  int          stall_phase = 0;

  object_to_ego_frame_matcher_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_veh_x          (in_veh_x),
    .in_veh_y          (in_veh_y),
    .in_last_vehicle   (in_last_vehicle),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_rel_x         (out_rel_x),
    .out_rel_y         (out_rel_y),
    .out_match_flag    (out_match_flag),
    .out_vehicle_index (out_vehicle_index),
    .out_target_index  (out_target_index),
    .out_list_end      (out_list_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [39:0] rand40();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[39:0];
  endfunction

  // Q.14 back to integer: round half up (floor of v + half), then clamp to 32 bits
  function automatic longint round_q14(input longint v);
    longint r;
    r = (v + 64'sd8192) >>> 14;
    if (r > REL_MAX) r = REL_MAX;
    else if (r < REL_MIN) r = REL_MIN;
    return r;
  endfunction

  function automatic void rotate_offset(input longint dx, input longint dy, input longint cs,
                                        input longint sn, output longint rx, output longint ry);
    rx = round_q14(dx * cs - dy * sn);
    ry = round_q14(dx * sn + dy * cs);
  endfunction

  // register write as the block sees it; unknown indexes are dropped
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] wdata);
    case (idx)
      REG_EGO_X:        cfg_ego_x  = longint'($signed(wdata[39:0]));
      REG_EGO_Y:        cfg_ego_y  = longint'($signed(wdata[39:0]));
      REG_ROT_COS:      cfg_cos    = longint'($signed(wdata[15:0]));
      REG_ROT_SIN:      cfg_sin    = longint'($signed(wdata[15:0]));
      REG_TARGET_VALID: cfg_tvalid = wdata[0];
      REG_TARGET_X:     cfg_tgt_x  = longint'($signed(wdata[31:0]));
      REG_TARGET_Y:     cfg_tgt_y  = longint'($signed(wdata[31:0]));
      REG_RADIUS:       cfg_radius = longint'(wdata[39:0]);
      default: ;
    endcase
  endfunction

  // transform, radius test and list tracking for one accepted vehicle word
  task automatic predict_vehicle(input logic signed [POS_W-1:0] vx,
                                 input logic signed [POS_W-1:0] vy, input logic is_last);
    longint      rx, ry, ax, ay;
    ego_result_t r;
    rotate_offset(longint'(vx) - cfg_ego_x, longint'(vy) - cfg_ego_y, cfg_cos, cfg_sin, rx, ry);
    r.flag = MF_OFF;
    if (cfg_tvalid) begin
      ax = cfg_tgt_x - rx;
      ay = cfg_tgt_y - ry;
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      r.flag = MF_OUT;
      if (ax < NEAR_LIM && ay < NEAR_LIM) begin
        if (ax * ax + ay * ay < cfg_radius) begin
          r.flag = MF_IN;
          list_match = list_count;
        end
      end
    end
    r.rel_x = rx[31:0];
    r.rel_y = ry[31:0];
    r.vidx  = list_count[7:0];
    r.tidx  = list_match[8:0];
    r.lend  = is_last;
    expected_results.push_back(r);
    if (is_last) begin
      list_count = 0;
      list_match = -1;
    end else if (list_count < MAX_VEH_DEF - 1) begin
      list_count++;
    end
  endtask

  task automatic queue_vehicle(input longint x, input longint y, input bit is_last);
    pending_words.push_back('{W_VEHICLE, x[39:0], y[39:0], is_last, '0, '0});
  endtask

  task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] wdata);
    pending_words.push_back('{W_WRITE, '0, '0, 1'b0, idx, wdata});
  endtask

  // wait for the block to go idle, then load all eight registers;
  // narrow registers sometimes get junk in the unused upper bits
  task automatic queue_setting(input longint ex, input longint ey, input longint cs,
                               input longint sn, input int tv, input longint tx,
                               input longint ty, input longint rad);
    logic [39:0] junk;
    junk = ($urandom_range(3, 0) == 0) ? rand40() : '0;
    pending_words.push_back('{W_SETTLE, '0, '0, 1'b0, '0, '0});
    queue_write(REG_EGO_X, ex[39:0]);
    queue_write(REG_EGO_Y, ey[39:0]);
    queue_write(REG_ROT_COS, {junk[39:16], cs[15:0]});
    queue_write(REG_ROT_SIN, {junk[39:16], sn[15:0]});
    queue_write(REG_TARGET_VALID, {junk[39:1], tv[0]});
    queue_write(REG_TARGET_X, {junk[39:32], tx[31:0]});
    queue_write(REG_TARGET_Y, {junk[39:32], ty[31:0]});
    queue_write(REG_RADIUS, rad[39:0]);
  endtask

  // driver: one word at a time from the pending queue, in bursts with gaps
  always @(posedge clk) begin
    logic nxt_in_valid;
    logic nxt_cfg_valid;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nxt_in_valid  = in_valid;
      nxt_cfg_valid = cfg_valid;
      if (in_valid && !in_stall) begin
        predict_vehicle(in_veh_x, in_veh_y, in_last_vehicle);
        nxt_in_valid = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
        nxt_cfg_valid = 1'b0;
      end
      if (!nxt_in_valid && !nxt_cfg_valid && pending_words.size() != 0) begin
        case (pending_words[0].kind)
          W_SETTLE: begin
            if (expected_results.size() != 0) begin
              settle_cnt = 0;
            end else if (settle_cnt >= SETTLE_CYCLES) begin
              settle_cnt = 0;
              pending_words.delete(0);
            end else begin
              settle_cnt++;
            end
          end
          W_WRITE: begin
            cfg_index     <= pending_words[0].reg_idx;
            cfg_data      <= pending_words[0].reg_data;
            nxt_cfg_valid = 1'b1;
            pending_words.delete(0);
          end
          default: begin
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              in_veh_x        <= pending_words[0].veh_x;
              in_veh_y        <= pending_words[0].veh_y;
              in_last_vehicle <= pending_words[0].is_last;
              nxt_in_valid    = 1'b1;
              pending_words.delete(0);
              if (burst_left <= 1) begin
                gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
                burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 40)
                                                          : $urandom_range(24, 1);
              end else begin
                burst_left--;
              end
            end
          end
        endcase
      end
      in_valid  <= nxt_in_valid;
      cfg_valid <= nxt_cfg_valid;
    end
  end

  // receiver stall: switches among a few patterns every so often
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(3, 0));
      stall_left = $urandom_range(150, 30);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      ST_NONE:  out_stall <= 1'b0;
      ST_LIGHT: out_stall <= ($urandom_range(2, 0) == 0);
      ST_HEAVY: out_stall <= ($urandom_range(2, 0) != 0);
      default:  out_stall <= (stall_phase < 3);
    endcase
    stall_phase = (stall_phase == 6) ? 0 : stall_phase + 1;
  end

  // monitor: each accepted result word against the oldest expectation
  always @(posedge clk) begin
    ego_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: rel_x %0d rel_y %0d", out_rel_x, out_rel_y);
        n_errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_rel_x !== exp_r.rel_x) begin
          $error("rel_x: expected %0d, got %0d", exp_r.rel_x, out_rel_x);
          n_errors++;
        end
        if (out_rel_y !== exp_r.rel_y) begin
          $error("rel_y: expected %0d, got %0d", exp_r.rel_y, out_rel_y);
          n_errors++;
        end
        if (out_match_flag !== exp_r.flag) begin
          $error("match_flag: expected %0d, got %0d", exp_r.flag, out_match_flag);
          n_errors++;
        end
        if (out_vehicle_index !== exp_r.vidx) begin
          $error("vehicle_index: expected %0d, got %0d", exp_r.vidx, out_vehicle_index);
          n_errors++;
        end
        if (out_target_index !== exp_r.tidx) begin
          $error("target_index: expected %0d, got %0d", exp_r.tidx, out_target_index);
          n_errors++;
        end
        if (out_list_end !== exp_r.lend) begin
          $error("list_end: expected %0d, got %0d", exp_r.lend, out_list_end);
          n_errors++;
        end
      end
    end
  end

  initial begin
    longint      ex, ey, cs, sn, tx, ty, rad, hx, hy, rx, ry, px, py, spread;
    int          tv, far_mode, long_phase, n_rand, n_items, len, k, phase;
    real         ang;
    int unsigned cycles;

    // reset defaults: matching off, identity rotation, position extremes saturate
    queue_vehicle(0, 0, 1'b0);
    queue_vehicle(POS_MAX, POS_MAX, 1'b0);
    queue_vehicle(POS_MIN, POS_MIN, 1'b0);
    queue_vehicle(POS_MAX, POS_MIN, 1'b0);
    queue_vehicle(POS_MIN, POS_MAX, 1'b1);

    // identity rotation with offset ego: hit, radius boundary, miss after match, list end
    queue_setting(1000, -2000, 16384, 0, 1, 5000, 7000, 16384);
    queue_write(4'(REG_COUNT + 1), rand40());
    queue_vehicle(6000, 5000, 1'b0);
    queue_vehicle(6128, 5000, 1'b0);
    queue_vehicle(6127, 5000, 1'b0);
    queue_vehicle(3006000, 5000, 1'b0);
    queue_vehicle(POS_MIN, 5000, 1'b1);
    queue_vehicle(6000, 9000, 1'b1);

    // rotation terms beyond unit scale, ego at extremes, zero radius
    queue_setting(POS_MIN, POS_MAX, -32768, 32767, 1, REL_MIN, REL_MAX, 0);
    queue_vehicle(POS_MAX, POS_MIN, 1'b0);
    queue_vehicle(POS_MIN, POS_MAX, 1'b0);
    queue_vehicle(0, 0, 1'b1);

    // random phases: a hot spot near the target plus noise words
    phase  = 0;
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      long_phase = (phase == 2);
      far_mode   = !long_phase && ($urandom_range(4, 0) == 0);
      ex = longint'($signed(rand40()));
      ey = longint'($signed(rand40()));
      if (!far_mode) begin
        ex = ex >>> 2;
        ey = ey >>> 2;
      end
      if ($urandom_range(7, 0) == 0) begin
        cs = longint'($signed(16'($urandom())));
        sn = longint'($signed(16'($urandom())));
      end else begin
        ang = $urandom_range(359, 0) * PI / 180.0;
        cs  = $rtoi(16384.0 * $cos(ang));
        sn  = $rtoi(16384.0 * $sin(ang));
      end
      tv = long_phase || ($urandom_range(3, 0) != 0);
      hx = ex + longint'($urandom_range(131072, 0)) - 65536;
      hy = ey + longint'($urandom_range(131072, 0)) - 65536;
      rotate_offset(hx - ex, hy - ey, cs, sn, rx, ry);
      spread = $urandom_range(3000, 1);
      case ($urandom_range(7, 0))
        0:       rad = 0;
        1:       rad = RAD_MAX;
        2:       rad = longint'(rand40());
        default: rad = spread * spread;
      endcase
      if (long_phase) rad = RAD_MAX;
      tx = rx + longint'($urandom_range(100, 0)) - 50;
      ty = ry + longint'($urandom_range(100, 0)) - 50;
      if (far_mode) begin
        tx = longint'($signed($urandom()));
        ty = longint'($signed($urandom()));
      end
      queue_setting(ex, ey, cs, sn, tv, tx, ty, rad);
      if ($urandom_range(3, 0) == 0) queue_write(4'($urandom_range(15, REG_COUNT)), rand40());

      n_items = long_phase ? LONG_LIST + 30 : $urandom_range(80, 30);
      len     = long_phase ? LONG_LIST : $urandom_range(12, 1);
      while (n_items > 0) begin
        if (len > n_items) len = n_items;
        for (k = 0; k < len; k++) begin
          if (far_mode || $urandom_range(3, 0) == 0) begin
            px = longint'($signed(rand40()));
            py = longint'($signed(rand40()));
          end else begin
            px = hx + longint'($urandom_range(2 * spread, 0)) - spread;
            py = hy + longint'($urandom_range(2 * spread, 0)) - spread;
          end
          queue_vehicle(px, py, k == len - 1);
        end
        n_items -= len;
        n_rand  += len;
        len = $urandom_range(12, 1);
      end
      phase++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // sampled off the falling edge so the driver's updates have settled
    cycles = 0;
    while (cycles < LIMIT_CYCLES && (pending_words.size() != 0 || in_valid || cfg_valid ||
                                     expected_results.size() != 0)) begin
      @(negedge clk);
      cycles++;
    end

    if (cycles >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (expected_results.size() != 0) begin
        $error("%0d result words never arrived", expected_results.size());
        n_errors++;
      end
      if (n_errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
